>>> sv/cmvg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmvg_pkg
// Shared types, constants and the quarter-wave sine table of the cylinder
// mesh vertex generator.
// ----------------------------------------------------------------------------
package cmvg_pkg;

	localparam int MAX_SIDES_DEF           = 256;
	localparam int MAX_HEIGHT_SEGMENTS_DEF = 256;
	localparam int SINE_TABLE_DEPTH        = 256;
	localparam int SIN_AW                  = $clog2(SINE_TABLE_DEPTH);
	localparam int FRAC_BITS               = 14;
	localparam int FX_ONE                  = 1 << FRAC_BITS;
	localparam int FX_HALF                 = 1 << (FRAC_BITS - 1);
	localparam int DIV_W                   = 26;

	// pi/2 in Q.30
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	localparam logic [0:0] REG_SIDES    = 1'b0;
	localparam logic [0:0] REG_SEGMENTS = 1'b1;

	typedef enum logic [1:0] {
		RGN_CURVED  = 2'd0,
		RGN_RIM     = 2'd1,
		RGN_CENTER  = 2'd2,
		RGN_INVALID = 2'd3
	} region_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PHASE,
		ST_TEXU,
		ST_TEXV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] num;
		logic [DIV_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quo;
	} div_rsp_t;

	typedef logic [SINE_TABLE_DEPTH-1:0][15:0] sin_tab_t;

	// shift-subtract quotient, used only while building the table
	function automatic longint unsigned udiv64(input longint unsigned num,
			input longint unsigned den);
		longint unsigned q, r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= den) begin
				r = r - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Q.30 Taylor series, rounded to FRAC_BITS
	function automatic sin_tab_t build_sin_tab();
		sin_tab_t        tab;
		longint unsigned x, term;
		longint          sum, v;
		tab = '0;
		for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
			x = (64'(k) * HALF_PI_Q30 + (64'd1 << (SIN_AW - 1))) >> SIN_AW;
			term = x;
			sum = longint'(x);
			for (int n = 1; n <= 7; n++) begin
				term = (((term * x) >> 30) * x) >> 30;
				term = udiv64(term, 64'((2 * n) * (2 * n + 1)));
				if (n[0]) sum = sum - longint'(term);
				else sum = sum + longint'(term);
			end
			if (sum < 0) sum = 0;
			v = (sum + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
			if (v > FX_ONE) v = FX_ONE;
			tab[k] = v[15:0];
		end
		return tab;
	endfunction

	localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage
`default_nettype wire

>>> sv/cmvg_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmvg_div
// Restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module cmvg_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmvg_pkg::div_req_t req,
	output cmvg_pkg::div_rsp_t     rsp
);
	localparam int W  = cmvg_pkg::DIV_W;
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  rem_q, quo_q, den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [W:0]    trial;

	assign trial = {rem_q, quo_q[W-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
endmodule
`default_nettype wire

>>> sv/cylinder_mesh_vertex_gen.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cylinder_mesh_vertex_gen
// Emits the vertices of a tessellated unit cylinder, one per request.
// ----------------------------------------------------------------------------
// With the output free, a request on the curved surface makes three divider
// passes (angle phase, tex u, tex v), then passes through the output state
// and returns to idle. A rim vertex takes one pass, and a cap center none.
// All passes use the single shared restoring divider. The output register
// lets the next request be accepted while a vertex waits.
module cylinder_mesh_vertex_gen #(
	parameter int MAX_SIDES           = cmvg_pkg::MAX_SIDES_DEF,
	parameter int MAX_HEIGHT_SEGMENTS = cmvg_pkg::MAX_HEIGHT_SEGMENTS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [0:0]        cfg_index,
	input  wire logic [8:0]        cfg_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              restart,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic signed [14:0]     pos_x,
	output logic signed [14:0]     pos_y,
	output logic signed [14:0]     pos_z,
	output logic signed [14:0]     norm_x,
	output logic signed [15:0]     norm_y,
	output logic signed [14:0]     norm_z,
	output logic [14:0]            tex_u,
	output logic [14:0]            tex_v,
	output logic                   last_vertex
);
	localparam int D   = cmvg_pkg::SINE_TABLE_DEPTH;
	localparam int AW  = cmvg_pkg::SIN_AW;
	localparam int W   = cmvg_pkg::DIV_W;
	localparam int ONE = cmvg_pkg::FX_ONE;

	logic [8:0] sides_q, segs_q;
	logic [8:0] s_eff, h_eff;
	logic [7:0] side_q;
	logic [8:0] level_q;
	cmvg_pkg::region_t rgn_q;
	logic cap_q;
	cmvg_pkg::state_t st_q, st_d;
	logic [AW+1:0] phase_q;
	logic [14:0] tu_q, tv_q;
	logic        out_free;

	cmvg_pkg::div_req_t dreq;
	cmvg_pkg::div_rsp_t drsp;

	cmvg_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	always_comb begin
		s_eff = (sides_q < 9'd3) ? 9'd3 :
			((32'(sides_q) > MAX_SIDES) ? 9'(MAX_SIDES) : sides_q);
		h_eff = (segs_q == 9'd0) ? 9'd1 :
			((32'(segs_q) > MAX_HEIGHT_SEGMENTS) ? 9'(MAX_HEIGHT_SEGMENTS) : segs_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sides_q <= 9'd16;
			segs_q  <= 9'd1;
		end else if (cfg_we) begin
			if (cfg_index == cmvg_pkg::REG_SIDES) sides_q <= cfg_data;
			else segs_q <= cfg_data;
		end
	end

	// position normalization on accept
	logic       bad;
	logic       acc;
	assign acc = in_valid && in_ready;
	assign bad = restart || rgn_q == cmvg_pkg::RGN_INVALID ||
		(rgn_q != cmvg_pkg::RGN_CENTER && 9'(side_q) >= s_eff) ||
		(rgn_q == cmvg_pkg::RGN_CURVED && level_q > h_eff);

	assign out_free = !out_valid || out_ready;
	assign in_ready = (st_q == cmvg_pkg::ST_IDLE);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			cmvg_pkg::ST_IDLE: if (acc) begin
				if (!bad && rgn_q == cmvg_pkg::RGN_CENTER) st_d = cmvg_pkg::ST_OUT;
				else st_d = cmvg_pkg::ST_PHASE;
			end
			cmvg_pkg::ST_PHASE: if (drsp.done)
				st_d = (rgn_q == cmvg_pkg::RGN_CURVED) ? cmvg_pkg::ST_TEXU : cmvg_pkg::ST_OUT;
			cmvg_pkg::ST_TEXU: if (drsp.done) st_d = cmvg_pkg::ST_TEXV;
			cmvg_pkg::ST_TEXV: if (drsp.done) st_d = cmvg_pkg::ST_OUT;
			cmvg_pkg::ST_OUT: if (out_free) st_d = cmvg_pkg::ST_IDLE;
			default: st_d = cmvg_pkg::ST_IDLE;
		endcase
	end

	logic [9:0] dabs;
	always_comb begin
		dabs = (10'(s_eff) >= {1'b0, side_q, 1'b0}) ?
			10'(s_eff) - {1'b0, side_q, 1'b0} : {1'b0, side_q, 1'b0} - 10'(s_eff);
	end

	logic start_d;
	always_comb begin
		dreq = '0;
		start_d = 1'b0;
		unique case (st_q)
			cmvg_pkg::ST_IDLE:  start_d = acc;
			cmvg_pkg::ST_PHASE: start_d = drsp.done && rgn_q == cmvg_pkg::RGN_CURVED;
			cmvg_pkg::ST_TEXU:  start_d = drsp.done;
			default:            start_d = 1'b0;
		endcase
		dreq.start = start_d;
		if (st_q == cmvg_pkg::ST_IDLE) begin
			// a restarted mesh begins at side 0
			dreq.num = W'(bad ? 8'd0 : side_q) * W'(8 * D) + W'(s_eff);
			dreq.den = W'(s_eff) << 1;
		end else if (st_q == cmvg_pkg::ST_PHASE) begin
			dreq.num = (W'(dabs) << (cmvg_pkg::FRAC_BITS + 1)) + W'(s_eff);
			dreq.den = W'(s_eff) << 1;
		end else begin
			dreq.num = (W'(level_q) << (cmvg_pkg::FRAC_BITS + 1)) + W'(h_eff);
			dreq.den = W'(h_eff) << 1;
		end
	end

	// sine lookup from phase
	function automatic logic signed [16:0] sinp(input logic [AW+1:0] p);
		logic [AW:0] k;
		logic [15:0] m;
		k = p[AW] ? (AW+1)'(D) - {1'b0, p[AW-1:0]} : {1'b0, p[AW-1:0]};
		m = k[AW] ? 16'(ONE) : cmvg_pkg::SIN_TAB[k[AW-1:0]];
		return p[AW+1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
	endfunction

	logic signed [16:0] sn, cs;
	logic signed [14:0] hx, hz;
	always_comb begin
		sn = sinp(phase_q);
		cs = sinp(phase_q + (AW+2)'(D));
		hx = cs[16] ? -15'((-cs + 17'sd1) >>> 1) : 15'((cs + 17'sd1) >>> 1);
		hz = sn[16] ? -15'((-sn + 17'sd1) >>> 1) : 15'((sn + 17'sd1) >>> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= cmvg_pkg::ST_IDLE;
			side_q <= '0; level_q <= '0; rgn_q <= cmvg_pkg::RGN_CURVED; cap_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == cmvg_pkg::ST_OUT && out_free) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (acc && bad) begin
				side_q <= '0; level_q <= '0; rgn_q <= cmvg_pkg::RGN_CURVED; cap_q <= 1'b0;
			end
			if (st_q == cmvg_pkg::ST_OUT && out_free) begin
				unique case (rgn_q)
					cmvg_pkg::RGN_CURVED: begin
						if (level_q >= h_eff) begin
							level_q <= '0;
							if (9'(side_q) + 9'd1 >= s_eff) begin
								side_q <= '0; rgn_q <= cmvg_pkg::RGN_RIM; cap_q <= 1'b0;
							end else side_q <= side_q + 8'd1;
						end else level_q <= level_q + 9'd1;
					end
					cmvg_pkg::RGN_RIM: begin
						cap_q <= !cap_q;
						if (cap_q) begin
							if (9'(side_q) + 9'd1 >= s_eff) begin
								side_q <= '0; rgn_q <= cmvg_pkg::RGN_CENTER;
							end else side_q <= side_q + 8'd1;
						end
					end
					default: begin
						if (!cap_q) cap_q <= 1'b1;
						else begin
							side_q <= '0; level_q <= '0;
							rgn_q <= cmvg_pkg::RGN_CURVED; cap_q <= 1'b0;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == cmvg_pkg::ST_PHASE && drsp.done) phase_q <= drsp.quo[AW+1:0];
		if (st_q == cmvg_pkg::ST_TEXU && drsp.done) tu_q <= drsp.quo[14:0];
		if (st_q == cmvg_pkg::ST_TEXV && drsp.done) tv_q <= drsp.quo[14:0];
		if (st_q == cmvg_pkg::ST_OUT && out_free) begin
			unique case (rgn_q)
				cmvg_pkg::RGN_CURVED: begin
					pos_x <= hx; pos_z <= hz; norm_x <= hx; norm_z <= hz;
					norm_y <= '0; tex_u <= tu_q; tex_v <= tv_q;
					pos_y  <= tv_q - 15'(cmvg_pkg::FX_HALF);
					last_vertex <= 1'b0;
				end
				cmvg_pkg::RGN_RIM: begin
					pos_x <= hx; pos_z <= hz; norm_x <= '0; norm_z <= '0;
					norm_y <= cap_q ? 16'(ONE) : -16'(ONE);
					pos_y  <= cap_q ? 15'(cmvg_pkg::FX_HALF) : -15'(cmvg_pkg::FX_HALF);
					tex_u  <= 15'((cs + 17'(ONE) + 17'sd1) >>> 1);
					tex_v  <= 15'((sn + 17'(ONE) + 17'sd1) >>> 1);
					last_vertex <= 1'b0;
				end
				default: begin
					pos_x <= '0; pos_z <= '0; norm_x <= '0; norm_z <= '0;
					norm_y <= cap_q ? 16'(ONE) : -16'(ONE);
					pos_y  <= cap_q ? 15'(cmvg_pkg::FX_HALF) : -15'(cmvg_pkg::FX_HALF);
					tex_u  <= 15'(cmvg_pkg::FX_HALF);
					tex_v  <= 15'(cmvg_pkg::FX_HALF);
					last_vertex <= cap_q;
				end
			endcase
		end
	end

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (st_q == cmvg_pkg::ST_IDLE)) else $error("ready mismatch");
	a_one_out: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == cmvg_pkg::ST_OUT && out_free) |=> out_valid) else $error("lost vertex");
	a_no_busy_accept: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> !in_ready) else $error("accepted while busy");
endmodule
`default_nettype wire
